FILE: hdl/pram_pkg.sv
// ----------------------------------------------------------------------------
// pram_pkg: shared types and constants for the priority access rule matcher
// Rule and command formats, action and status codes, table sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package pram_pkg;

    localparam int RULES       = 32;
    localparam int ID_BITS     = 16;
    localparam int PERM_BITS   = 8;
    localparam int ACT_W       = 2;
    localparam int PRIO_W      = 8;
    localparam int IDX_OUT_W   = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam int IDX_W  = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W  = $clog2(RULES + 1);
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [ACT_W-1:0] ACT_DENY    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ALLOW   = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [ID_BITS-1:0]   subj;
        logic [ID_BITS-1:0]   obj;
        logic [PERM_BITS-1:0] perm;
        logic [ACT_W-1:0]     act;
        logic [PRIO_W-1:0]    prio;
    } rule_t;

    typedef struct packed {
        logic  is_eval;
        rule_t rule;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0]     decision;
        logic                 hit;
        logic [IDX_OUT_W-1:0] rule_index;
        logic                 status;
    } res_t;

    // table index to the 5-bit reported index (zero extend, then keep low bits)
    function automatic logic [IDX_OUT_W-1:0] idx_to_out(input logic [IDX_W-1:0] idx);
        logic [IDX_W+IDX_OUT_W-1:0] wide;
        wide = {{IDX_OUT_W{1'b0}}, idx};
        return wide[IDX_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pram_front.sv
// ----------------------------------------------------------------------------
// pram_front: ingress and command queue
// Accepts transactions, forms a command (action clamped) and queues it for
// the rule engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pram_front
    import pram_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 opcode,
    input  wire logic [ID_BITS-1:0]   subject_id,
    input  wire logic [ID_BITS-1:0]   object_id,
    input  wire logic [PERM_BITS-1:0] perm_mask,
    input  wire logic [ACT_W-1:0]     rule_action,
    input  wire logic [PRIO_W-1:0]    rule_priority,
    output logic                      q_valid,
    output cmd_t                      q_cmd,
    input  wire logic                 q_pop
);

    localparam logic [QCNT_W-1:0] QFULL   = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] QLAST   = QPTR_W'(QUEUE_DEPTH - 1);

    cmd_t               q_mem [QUEUE_DEPTH];
    cmd_t               cmd_in;
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;
    logic               push;
    logic               pop;

    always_comb
    begin
        cmd_in.is_eval   = (opcode == OP_EVAL);
        cmd_in.rule.subj = subject_id;
        cmd_in.rule.obj  = object_id;
        cmd_in.rule.perm = perm_mask;
        cmd_in.rule.act  = (rule_action > ACT_ALLOW) ? ACT_ALLOW : rule_action;
        cmd_in.rule.prio = rule_priority;
    end

    assign in_ready = (fill_reg != QFULL);
    assign q_valid  = (fill_reg != '0);
    assign q_cmd    = q_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QLAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QLAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pram_engine.sv
// ----------------------------------------------------------------------------
// pram_engine: rule table and evaluation engine
// Appends rules to the table and scans it one rule per cycle for requests,
// keeping the first highest-priority match; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pram_engine
    import pram_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      out_vld,
    output res_t      out_res,
    input  wire logic out_ready
);

    localparam logic [CNT_W-1:0] RULES_CNT = CNT_W'(RULES);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    rule_t              mem [RULES];
    rule_t              rd_data_reg;
    logic               mem_we;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    rule_t              req_reg, req_next;
    logic               best_vld_reg, best_vld_next;
    logic [PRIO_W-1:0]  best_prio_reg, best_prio_next;
    logic [ACT_W-1:0]   best_act_reg, best_act_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               out_vld_reg, out_vld_next;
    res_t               res_reg, res_next;
    logic               out_free;
    logic               rule_match;

    function automatic logic id_ok(input logic [ID_BITS-1:0] a, input logic [ID_BITS-1:0] b);
        return (a == '0) || (b == '0) || (a == b);
    endfunction

    assign out_vld  = out_vld_reg;
    assign out_res  = res_reg;
    assign out_free = !out_vld_reg || out_ready;

    assign rule_match = id_ok(rd_data_reg.subj, req_reg.subj)
                     && id_ok(rd_data_reg.obj, req_reg.obj)
                     && ((rd_data_reg.perm & req_reg.perm) != '0);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = issue_reg[IDX_W-1:0];
        req_next       = req_reg;
        best_vld_next  = best_vld_reg;
        best_prio_next = best_prio_reg;
        best_act_next  = best_act_reg;
        best_idx_next  = best_idx_reg;
        out_vld_next   = out_ready ? 1'b0 : out_vld_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.is_eval)
                    begin
                        q_pop          = 1'b1;
                        req_next       = q_cmd.rule;
                        best_vld_next  = 1'b0;
                        best_prio_next = '0;
                        best_act_next  = ACT_ALLOW;
                        best_idx_next  = '0;
                        issue_next     = '0;
                        state_next     = ST_SCAN;
                    end
                    else if (out_free)
                    begin
                        q_pop               = 1'b1;
                        out_vld_next        = 1'b1;
                        res_next.decision   = ACT_DENY;
                        res_next.hit        = 1'b0;
                        if (count_reg < RULES_CNT)
                        begin
                            mem_we              = 1'b1;
                            count_next          = count_reg + 1'b1;
                            res_next.rule_index = idx_to_out(count_reg[IDX_W-1:0]);
                            res_next.status     = STATUS_OK;
                        end
                        else
                        begin
                            res_next.rule_index = '0;
                            res_next.status     = STATUS_FULL;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // strict compare keeps the earliest of equal priorities
                if (cmp_vld_reg && rule_match
                    && (!best_vld_reg || (rd_data_reg.prio > best_prio_reg)))
                begin
                    best_vld_next  = 1'b1;
                    best_prio_next = rd_data_reg.prio;
                    best_act_next  = rd_data_reg.act;
                    best_idx_next  = cmp_idx_reg;
                end
                if (issue_reg != count_reg)
                begin
                    cmp_vld_next = 1'b1;
                    issue_next   = issue_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next        = 1'b1;
                    res_next.decision   = best_act_reg;
                    res_next.hit        = best_vld_reg;
                    res_next.rule_index = idx_to_out(best_idx_reg);
                    res_next.status     = STATUS_OK;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            cmp_vld_reg  <= cmp_vld_next;
            best_vld_reg <= best_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        req_reg       <= req_next;
        best_prio_reg <= best_prio_next;
        best_act_reg  <= best_act_next;
        best_idx_reg  <= best_idx_next;
        res_reg       <= res_next;
    end

    // rule table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= q_cmd.rule;
        end
        rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
    end

endmodule

`default_nettype wire

FILE: hdl/priority_access_rule_matcher.sv
// ----------------------------------------------------------------------------
// priority_access_rule_matcher: priority rule access control list
// Appends access rules and evaluates requests against them.
// ----------------------------------------------------------------------------
// A two-entry command queue sits in front of the rule engine, so new
// transactions are taken while the engine works or a result waits. An
// evaluate scans all N stored rules (up to 32): the table has a single
// read port and the scan reads one rule per cycle through its registered
// output, then loads the best match into the result register. Ids of 0
// are wildcards in rules and absent in requests; with no match the
// decision is allow.
`default_nettype none

module priority_access_rule_matcher
    import pram_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 opcode,
    input  wire logic [ID_BITS-1:0]   subject_id,
    input  wire logic [ID_BITS-1:0]   object_id,
    input  wire logic [PERM_BITS-1:0] perm_mask,
    input  wire logic [ACT_W-1:0]     rule_action,
    input  wire logic [PRIO_W-1:0]    rule_priority,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ACT_W-1:0]          decision,
    output logic                      hit,
    output logic [IDX_OUT_W-1:0]      rule_index,
    output logic                      status
);

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;
    res_t res;

    pram_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .subject_id    (subject_id),
        .object_id     (object_id),
        .perm_mask     (perm_mask),
        .rule_action   (rule_action),
        .rule_priority (rule_priority),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    pram_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_vld   (out_valid),
        .out_res   (res),
        .out_ready (out_ready)
    );

    assign decision   = res.decision;
    assign hit        = res.hit;
    assign rule_index = res.rule_index;
    assign status     = res.status;

endmodule

`default_nettype wire

FILE: hdl/pram_checker.sv
// ----------------------------------------------------------------------------
// pram_checker: port-level checks for the rule matcher
// Result field consistency and output hold under backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module pram_checker
    import pram_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 opcode,
    input wire logic [ID_BITS-1:0]   subject_id,
    input wire logic [ID_BITS-1:0]   object_id,
    input wire logic [PERM_BITS-1:0] perm_mask,
    input wire logic [ACT_W-1:0]     rule_action,
    input wire logic [PRIO_W-1:0]    rule_priority,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [ACT_W-1:0]     decision,
    input wire logic                 hit,
    input wire logic [IDX_OUT_W-1:0] rule_index,
    input wire logic                 status
);

    // table-full add reports deny, no hit, index zero
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FULL)
        |-> !hit && (decision == ACT_DENY) && (rule_index == '0))
        else $error("full-table result fields wrong");

    // evaluate miss: default allow at index zero
    a_miss_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit && (decision == ACT_ALLOW)
        |-> (rule_index == '0) && (status == STATUS_OK))
        else $error("miss result fields wrong");

    // a hit carries a stored action and ok status
    a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit
        |-> (status == STATUS_OK)
            && ((decision == ACT_DENY) || (decision == ACT_UNKNOWN)
                || (decision == ACT_ALLOW)))
        else $error("hit result fields wrong");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(decision) && $stable(hit)
            && $stable(rule_index) && $stable(status))
        else $error("stalled result changed");

endmodule

bind priority_access_rule_matcher pram_checker u_pram_checker (.*);

`default_nettype wire

FILE: verif/rule_match_checker.sv
// ----------------------------------------------------------------------------
// rule_match_checker: scoreboard for the priority access rule matcher
// Watches both channels, keeps a shadow rule table, predicts the result of
// every accepted command and compares it field by field with the block.
// ----------------------------------------------------------------------------
module rule_match_checker
    import pram_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 opcode,
    input  logic [ID_BITS-1:0]   subject_id,
    input  logic [ID_BITS-1:0]   object_id,
    input  logic [PERM_BITS-1:0] perm_mask,
    input  logic [ACT_W-1:0]     rule_action,
    input  logic [PRIO_W-1:0]    rule_priority,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [ACT_W-1:0]     decision,
    input  logic                 hit,
    input  logic [IDX_OUT_W-1:0] rule_index,
    input  logic                 status,
    output int                   fail_count,
    output int                   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    rule_t       shadow_rules [RULES];
    int unsigned shadow_count;
    res_t        pending_decisions [$];

    initial fail_count = 0;

    // 0 is a wildcard on the rule side and "absent" on the request side
    function automatic bit ids_match(input logic [ID_BITS-1:0] rule_id,
                                     input logic [ID_BITS-1:0] req_id);
        return (rule_id == '0) || (req_id == '0) || (rule_id == req_id);
    endfunction

    // updates the shadow table and returns the result the block must give
    function automatic res_t apply_rule_cmd(input cmd_t c);
        res_t        r;
        int          best_prio;
        int unsigned i;
        r = '0;
        if (c.is_eval == OP_ADD) begin
            if (shadow_count >= RULES) begin
                r.status = STATUS_FULL;
            end
            else begin
                shadow_rules[shadow_count] = c.rule;
                if (c.rule.act > ACT_ALLOW)
                    shadow_rules[shadow_count].act = ACT_ALLOW;
                r.rule_index = shadow_count[IDX_OUT_W-1:0];
                shadow_count++;
            end
        end
        else begin
            best_prio  = -1;
            r.decision = ACT_ALLOW;
            for (i = 0; i < shadow_count; i++) begin
                if (ids_match(shadow_rules[i].subj, c.rule.subj) &&
                    ids_match(shadow_rules[i].obj, c.rule.obj) &&
                    (shadow_rules[i].perm & c.rule.perm) != '0 &&
                    int'(shadow_rules[i].prio) > best_prio) begin
                    best_prio    = int'(shadow_rules[i].prio);
                    r.decision   = shadow_rules[i].act;
                    r.hit        = 1'b1;
                    r.rule_index = i[IDX_OUT_W-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        cmd_t c;
        res_t want;
        if (!rst_n) begin
            shadow_count = 0;
            pending_decisions.delete();
            outstanding = 0;
        end
        else begin
            if (in_valid && in_ready) begin
                c.is_eval   = opcode;
                c.rule.subj = subject_id;
                c.rule.obj  = object_id;
                c.rule.perm = perm_mask;
                c.rule.act  = rule_action;
                c.rule.prio = rule_priority;
                pending_decisions.push_back(apply_rule_cmd(c));
            end
            if (out_valid && out_ready) begin
                if (pending_decisions.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result transaction with nothing outstanding", $time);
                end
                else begin
                    want = pending_decisions.pop_front();
                    if (decision !== want.decision)
                        flag_field("decision", 8'(want.decision), 8'(decision));
                    if (hit !== want.hit)
                        flag_field("hit", 8'(want.hit), 8'(hit));
                    if (rule_index !== want.rule_index)
                        flag_field("rule_index", 8'(want.rule_index), 8'(rule_index));
                    if (status !== want.status)
                        flag_field("status", 8'(want.status), 8'(status));
                end
            end
            outstanding = pending_decisions.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the priority access rule matcher
// Drives directed and random add/evaluate commands with random idling on
// both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    import pram_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1100;
    localparam int HOLD_AT        = 300;
    localparam int PAUSE_AT       = 800;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    // action code outside the defined set, must be stored as allow
    localparam logic [ACT_W-1:0] ACT_BAD = 2'd3;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 opcode        = OP_ADD;
    logic [ID_BITS-1:0]   subject_id    = '0;
    logic [ID_BITS-1:0]   object_id     = '0;
    logic [PERM_BITS-1:0] perm_mask     = '0;
    logic [ACT_W-1:0]     rule_action   = ACT_DENY;
    logic [PRIO_W-1:0]    rule_priority = '0;
    logic                 out_ready     = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [ACT_W-1:0]     decision;
    logic                 hit;
    logic [IDX_OUT_W-1:0] rule_index;
    logic                 status;
    int                   fail_count;
    int                   outstanding;
    int                   idle_cycles   = 0;
    int                   no_gap_run    = 0;
    bit                   hold_req      = 1'b0;

    always #5 clk = ~clk;

    priority_access_rule_matcher dut (.*);

    rule_match_checker checker_i (.*);

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stalls, long ready stretches, one forced hold-off
    initial begin : sink
        int r;
        int len;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    out_ready <= 1'b1;
                    len = $urandom_range(1, 20);
                end
                else if (r < 62) begin
                    out_ready <= 1'b1;
                    len = $urandom_range(100, 300);
                end
                else if (r < 95) begin
                    out_ready <= 1'b0;
                    len = $urandom_range(1, 4);
                end
                else begin
                    out_ready <= 1'b0;
                    len = $urandom_range(20, 60);
                end
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    function automatic cmd_t make_cmd(input logic op, input logic [ID_BITS-1:0] subj,
                                      input logic [ID_BITS-1:0] obj,
                                      input logic [PERM_BITS-1:0] perm,
                                      input logic [ACT_W-1:0] act,
                                      input logic [PRIO_W-1:0] prio);
        cmd_t c;
        c.is_eval   = op;
        c.rule.subj = subj;
        c.rule.obj  = obj;
        c.rule.perm = perm;
        c.rule.act  = act;
        c.rule.prio = prio;
        return c;
    endfunction

    // small id pool so that requests actually hit stored rules
    function automatic logic [ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        else if (r < 70)
            return ID_BITS'($urandom_range(1, 6));
        else if (r < 80)
            return ($urandom_range(0, 1) != 0) ? '1 : ID_BITS'(1);
        else
            return ID_BITS'($urandom);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   r;
        c.is_eval   = ($urandom_range(0, 99) < 15) ? OP_ADD : OP_EVAL;
        c.rule.subj = pick_id();
        c.rule.obj  = pick_id();
        r = $urandom_range(0, 99);
        if (r < 10)
            c.rule.perm = '0;
        else if (r < 20)
            c.rule.perm = '1;
        else if (r < 40)
            c.rule.perm = PERM_BITS'(1) << $urandom_range(0, PERM_BITS - 1);
        else
            c.rule.perm = PERM_BITS'($urandom);
        c.rule.act = ACT_W'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        // low pool makes equal priorities common
        if (r < 40)
            c.rule.prio = PRIO_W'($urandom_range(0, 3));
        else if (r < 50)
            c.rule.prio = ($urandom_range(0, 1) != 0) ? '1 : '0;
        else
            c.rule.prio = PRIO_W'($urandom);
        return c;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_cmd(input cmd_t c);
        in_valid      <= 1'b1;
        opcode        <= c.is_eval;
        subject_id    <= c.rule.subj;
        object_id     <= c.rule.obj;
        perm_mask     <= c.rule.perm;
        rule_action   <= c.rule.act;
        rule_priority <= c.rule.prio;
        do @(posedge clk); while (in_ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int r;
        int len;
        if (no_gap_run > 0) begin
            no_gap_run--;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            no_gap_run = $urandom_range(30, 80);
            len = 0;
        end
        else if (r < 60)
            len = 0;
        else if (r < 95)
            len = $urandom_range(1, 4);
        else
            len = $urandom_range(15, 60);
        if (len > 0) begin
            in_valid <= 1'b0;
            repeat (len) @(negedge clk);
        end
    endtask

    initial begin : stimulus
        cmd_t directed [$];
        int   i;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, wildcard rule, mask overlap and the id extremes
        directed.push_back(make_cmd(OP_EVAL, '0, '0, '1, ACT_DENY, '0));
        directed.push_back(make_cmd(OP_ADD, '0, '0, 8'h01, ACT_DENY, '0));
        directed.push_back(make_cmd(OP_EVAL, 16'd5, 16'd7, 8'h01, ACT_ALLOW, '1));
        directed.push_back(make_cmd(OP_EVAL, 16'd5, 16'd7, 8'h02, ACT_DENY, '0));
        directed.push_back(make_cmd(OP_EVAL, 16'd5, 16'd7, 8'h00, ACT_DENY, '0));
        directed.push_back(make_cmd(OP_ADD, '1, '1, '1, ACT_UNKNOWN, '1));
        directed.push_back(make_cmd(OP_EVAL, '1, '1, 8'h80, ACT_DENY, '0));
        directed.push_back(make_cmd(OP_EVAL, '0, '0, 8'h01, ACT_DENY, '0));
        directed.push_back(make_cmd(OP_ADD, 16'd3, '0, 8'h01, ACT_BAD, '1));
        directed.push_back(make_cmd(OP_EVAL, 16'd3, '1, 8'h01, ACT_DENY, '0));
        // tie at top priority: the earlier rule must win
        directed.push_back(make_cmd(OP_EVAL, '0, '1, 8'h01, ACT_DENY, '0));
        directed.push_back(make_cmd(OP_ADD, 16'h1234, 16'h5678, 8'h10, ACT_ALLOW, 8'd128));
        directed.push_back(make_cmd(OP_EVAL, 16'h1234, 16'h5678, 8'h10, ACT_BAD, '1));
        directed.push_back(make_cmd(OP_EVAL, 16'h1235, 16'h5678, 8'h10, ACT_DENY, '0));
        directed.push_back(make_cmd(OP_EVAL, 16'h1234, '0, 8'hEF, ACT_DENY, '0));

        foreach (directed[k]) begin
            sender_gap();
            send_cmd(directed[k]);
        end

        // table fills part way through, then adds report full
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_AT)
                hold_req = 1'b1;
            if (i == PAUSE_AT) begin
                in_valid <= 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
            else begin
                sender_gap();
            end
            send_cmd(random_cmd());
        end
        in_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
